// ===== hdl/smwa_pkg.sv =====
// Shared types and constants for the soil moisture window averager.
package smwa_pkg;

    localparam int SAMPLE_W  = 10;
    localparam int MOIST_W   = 7;
    localparam int COUNT_W   = 16;
    localparam int SUM_W     = 23;
    localparam int DIVRES_W  = 20;
    localparam int SLOPE_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;
    localparam int DIV_STEPS = 7;
    localparam int STEP_W    = 3;

    localparam logic [SAMPLE_W-1:0] FULL_SCALE   = 10'd1023;
    localparam logic [MOIST_W-1:0]  MOISTURE_CAP = 7'd100;

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_ADD_FIN = 2'd1,
        OP_FIN     = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    localparam logic [CFG_IDX_W-1:0] CFG_DIV_RES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE   = 2'd1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic mul_slope;
        logic mul_read;
        logic sel_rev;
        logic div_init;
        logic div_step;
        logic save_first;
        logic accum;
        logic fin_load;
        logic emit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic window_full;
    } t_dp_stat;

endpackage

// ===== hdl/smwa_ifs.sv =====
// Valid/ready channel interfaces for sample pairs and window results.
interface smwa_in_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        operation;
    logic [smwa_pkg::SAMPLE_W-1:0]     forward_sample;
    logic [smwa_pkg::SAMPLE_W-1:0]     reverse_sample;

    modport source (output valid, operation, forward_sample, reverse_sample, input ready);
    modport sink   (input valid, operation, forward_sample, reverse_sample, output ready);
endinterface

interface smwa_out_if;
    logic                              valid;
    logic                              ready;
    logic [smwa_pkg::MOIST_W-1:0]      moisture_average;
    logic [smwa_pkg::COUNT_W-1:0]      pair_count;

    modport source (output valid, moisture_average, pair_count, input ready);
    modport sink   (input valid, moisture_average, pair_count, output ready);
endinterface

// ===== hdl/smwa_ctrl.sv =====
// Sequencing state machine for the moisture averager.
module smwa_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [1:0]          i_in_op,
    output logic                o_in_ready,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    input  smwa_pkg::t_dp_stat  i_stat,
    output smwa_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_SLOPE,
        S_MUL_READ,
        S_DIV_INIT,
        S_DIV,
        S_READ_DONE,
        S_FIN_LOAD,
        S_EMIT
    } t_state;

    t_state                        r_state;
    logic [smwa_pkg::STEP_W-1:0]   r_step;
    logic                          r_second;
    logic                          r_fin;
    logic                          r_fin_phase;
    logic                          r_out_valid;
    logic                          w_accept;
    logic                          w_out_free;
    smwa_pkg::t_op                 w_op;

    assign w_op       = smwa_pkg::t_op'(i_in_op);
    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd            = '0;
        o_cmd.load_in    = w_accept;
        o_cmd.mul_slope  = (r_state == S_MUL_SLOPE);
        o_cmd.mul_read   = (r_state == S_MUL_READ);
        o_cmd.sel_rev    = r_second;
        o_cmd.div_init   = (r_state == S_DIV_INIT);
        o_cmd.div_step   = (r_state == S_DIV);
        o_cmd.save_first = (r_state == S_READ_DONE) && !r_second;
        o_cmd.accum      = (r_state == S_READ_DONE) && r_second;
        o_cmd.fin_load   = (r_state == S_FIN_LOAD);
        o_cmd.emit       = (r_state == S_EMIT) && w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_second    <= 1'b0;
            r_fin       <= 1'b0;
            r_fin_phase <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_second <= 1'b0;
                        r_fin    <= (w_op == smwa_pkg::OP_ADD_FIN);
                        unique case (w_op)
                            smwa_pkg::OP_ADD, smwa_pkg::OP_ADD_FIN: begin
                                priority if (!i_stat.window_full) begin
                                    r_state <= S_MUL_SLOPE;
                                end else if (w_op == smwa_pkg::OP_ADD_FIN) begin
                                    r_state <= S_FIN_LOAD;
                                end else begin
                                    r_state <= S_IDLE;
                                end
                            end
                            smwa_pkg::OP_FIN: r_state <= S_FIN_LOAD;
                            smwa_pkg::OP_NONE: r_state <= S_IDLE;
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_MUL_SLOPE: r_state <= S_MUL_READ;
                S_MUL_READ:  r_state <= S_DIV_INIT;
                S_DIV_INIT: begin
                    r_step  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == smwa_pkg::STEP_W'(smwa_pkg::DIV_STEPS - 1)) begin
                        r_state <= r_fin_phase ? S_EMIT : S_READ_DONE;
                    end
                end
                S_READ_DONE: begin
                    if (!r_second) begin
                        r_second <= 1'b1;
                        r_state  <= S_MUL_READ;
                    end else begin
                        r_second <= 1'b0;
                        r_state  <= r_fin ? S_FIN_LOAD : S_IDLE;
                    end
                end
                S_FIN_LOAD: begin
                    r_fin_phase <= 1'b1;
                    r_state     <= S_DIV_INIT;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_fin_phase <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== hdl/smwa_dp.sv =====
// Datapath: calibration registers, multipliers, serial divider and window sums.
module smwa_dp #(
    parameter int MAX_PAIRS = 65535
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [smwa_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [smwa_pkg::CFG_DAT_W-1:0]        i_cfg_data,
    input  logic [smwa_pkg::SAMPLE_W-1:0]         i_fwd,
    input  logic [smwa_pkg::SAMPLE_W-1:0]         i_rev,
    input  smwa_pkg::t_dp_cmd                     i_cmd,
    output smwa_pkg::t_dp_stat                    o_stat,
    output logic [smwa_pkg::MOIST_W-1:0]          o_avg,
    output logic [smwa_pkg::COUNT_W-1:0]          o_pairs
);

    localparam int PROD_W = smwa_pkg::SLOPE_W + smwa_pkg::DIVRES_W;   // 52
    localparam int NUM_W  = PROD_W + smwa_pkg::SAMPLE_W;               // 62
    localparam int DEN_W  = smwa_pkg::SAMPLE_W + 16;                   // 26
    localparam int DSH_W  = DEN_W + smwa_pkg::DIV_STEPS - 1;           // 32

    logic [smwa_pkg::DIVRES_W-1:0] r_div_res;
    logic [smwa_pkg::SLOPE_W-1:0]  r_slope;
    logic [smwa_pkg::SAMPLE_W-1:0] r_fwd;
    logic [smwa_pkg::SAMPLE_W-1:0] r_rev;
    logic [PROD_W-1:0]             r_prod;
    logic [NUM_W-1:0]              r_rem;
    logic [DEN_W-1:0]              r_den;
    logic [DSH_W-1:0]              r_dsh;
    logic [smwa_pkg::MOIST_W-1:0]  r_quo;
    logic                          r_ovf;
    logic [smwa_pkg::MOIST_W-1:0]  r_m1;
    logic [smwa_pkg::SUM_W-1:0]    r_sum;
    logic [smwa_pkg::COUNT_W-1:0]  r_cnt;
    logic [smwa_pkg::MOIST_W-1:0]  r_avg;
    logic [smwa_pkg::COUNT_W-1:0]  r_pairs;

    logic [smwa_pkg::SAMPLE_W-1:0] w_v;
    logic [smwa_pkg::SAMPLE_W-1:0] w_span;
    logic [NUM_W-1:0]              w_dsh_ext;
    logic                          w_ge;
    logic [smwa_pkg::MOIST_W-1:0]  w_m;
    logic [smwa_pkg::MOIST_W:0]    w_pair_sum;

    // Reversed reading is inverted before conversion.
    assign w_v       = i_cmd.sel_rev ? (smwa_pkg::FULL_SCALE - r_rev) : r_fwd;
    assign w_span    = smwa_pkg::FULL_SCALE - w_v;
    assign w_dsh_ext = NUM_W'(r_dsh);
    assign w_ge      = (r_rem >= w_dsh_ext);

    // A full-scale reading has a zero divisor and so always trips the overflow clamp.
    assign w_m = (r_ovf || (r_quo > smwa_pkg::MOISTURE_CAP)) ? smwa_pkg::MOISTURE_CAP : r_quo;
    assign w_pair_sum = {1'b0, r_m1} + {1'b0, w_m};

    assign o_stat.window_full = (r_cnt >= smwa_pkg::COUNT_W'(MAX_PAIRS));
    assign o_avg   = r_avg;
    assign o_pairs = r_pairs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_res <= smwa_pkg::DIVRES_W'(10000);
            r_slope   <= smwa_pkg::SLOPE_W'(65536);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == smwa_pkg::CFG_DIV_RES) begin
                r_div_res <= i_cfg_data[smwa_pkg::DIVRES_W-1:0];
            end else if (i_cfg_idx == smwa_pkg::CFG_SLOPE) begin
                r_slope <= i_cfg_data[smwa_pkg::SLOPE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_fwd <= i_fwd;
            r_rev <= i_rev;
        end
        if (i_cmd.mul_slope) begin
            r_prod <= PROD_W'(r_slope) * PROD_W'(r_div_res);
        end
        if (i_cmd.mul_read) begin
            r_rem <= NUM_W'(r_prod) * NUM_W'(w_v);
            r_den <= {w_span, 16'd0};
        end else if (i_cmd.fin_load) begin
            r_rem <= NUM_W'(r_sum);
            r_den <= DEN_W'(r_cnt);
        end else if (i_cmd.div_step && w_ge) begin
            r_rem <= r_rem - w_dsh_ext;
        end
        if (i_cmd.div_init) begin
            // Quotient of 128 or more only ever clamps.
            r_ovf <= (r_rem >= NUM_W'({r_den, 7'd0}));
            r_dsh <= {r_den, 6'd0};
            r_quo <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[smwa_pkg::MOIST_W-2:0], w_ge};
            r_dsh <= r_dsh >> 1;
        end
        if (i_cmd.save_first) begin
            r_m1 <= w_m;
        end
        if (i_cmd.emit) begin
            r_avg   <= (r_cnt == '0) ? '0 : r_quo;
            r_pairs <= r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else if (i_cmd.emit) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else if (i_cmd.accum) begin
            r_sum <= r_sum + smwa_pkg::SUM_W'(w_pair_sum[smwa_pkg::MOIST_W:1]);
            r_cnt <= r_cnt + 1'b1;
        end
    end

endmodule

// ===== hdl/soil_moisture_window_average.sv =====
// Top level of the soil moisture window averager.
// Sequence: a pair item closes the input while the slope*resistor product is formed, then per
//   reading a product, a clamp check, 7 restoring-division steps and a done state; a finish
//   adds a load, a clamp check, the division and an emit. No item is taken before the last one
//   is through; a finish also waits in its emit state while an older result is held.
// Reset (synchronous, active low): clear the window, drop any pending result, reload calibration.
module soil_moisture_window_average #(
    parameter int MAX_PAIRS = 65535
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    smwa_in_if.sink                             i_in,
    smwa_out_if.source                          o_out,
    input  logic                                i_cfg_we,
    input  logic [smwa_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [smwa_pkg::CFG_DAT_W-1:0]      i_cfg_data
);

    smwa_pkg::t_dp_cmd  w_cmd;
    smwa_pkg::t_dp_stat w_stat;

    // Controller: accepts items only when idle, sequences the datapath and
    // owns the output valid so a finished result can wait while the next
    // item is taken in.
    smwa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_op     (i_in.operation),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // Datapath: calibration registers, two multiplier stages, the shared
    // restoring divider, the window sum/count and the output register.
    smwa_dp #(
        .MAX_PAIRS (MAX_PAIRS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_fwd      (i_in.forward_sample),
        .i_rev      (i_in.reverse_sample),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_avg      (o_out.moisture_average),
        .o_pairs    (o_out.pair_count)
    );

endmodule

// ===== hdl/smwa_chk.sv =====
// Port-level checks for the moisture averager, bound to the top level.
module smwa_chk #(
    parameter int MAX_PAIRS = 65535
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              i_in_ready,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic [smwa_pkg::MOIST_W-1:0]      i_avg,
    input logic [smwa_pkg::COUNT_W-1:0]      i_pairs
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result valid dropped while stalled");

    a_avg_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_avg <= smwa_pkg::MOISTURE_CAP))
        else $error("average above cap");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_pairs == '0)) |-> (i_avg == '0))
        else $error("empty window gave nonzero average");

    a_pairs_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_pairs <= smwa_pkg::COUNT_W'(MAX_PAIRS)))
        else $error("pair count above limit");

    a_not_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_valid && i_in_ready))
        else $error("result appeared one cycle after an item");

endmodule

bind soil_moisture_window_average smwa_chk #(
    .MAX_PAIRS (MAX_PAIRS)
) u_smwa_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_avg       (o_out.moisture_average),
    .i_pairs     (o_out.pair_count)
);

// ===== tb/soil_moisture_window_average_tb.sv =====
// Self-checking testbench for the soil moisture window averager.
module soil_moisture_window_average_tb;

    // Window limit of the block as built.
    localparam int TB_MAX_PAIRS   = 65535;
    localparam int MAX_WINDOW     = 16;
    localparam int PHASES         = 10;
    localparam int ITEMS_PER_PHASE = 55;
    localparam int MAX_GAP        = 12;
    // The longest item is a pair with finish.
    localparam int SETTLE_CYCLES  = 64;
    localparam int DRAIN_LIMIT    = 5000;
    localparam int TIMEOUT_UNITS  = 4_000_000;
    localparam int SIDE_IN        = 0;
    localparam int SIDE_OUT       = 1;

    // Register indexes past the end of the list; the block must ignore them.
    localparam logic [smwa_pkg::CFG_IDX_W-1:0] CFG_UNUSED_A = 2'd2;
    localparam logic [smwa_pkg::CFG_IDX_W-1:0] CFG_UNUSED_B = 2'd3;

    typedef struct {
        bit [smwa_pkg::MOIST_W-1:0] average;
        bit [smwa_pkg::COUNT_W-1:0] pairs;
    } t_window_result;

    // Predicts finished windows and compares them with what the block emits.
    class moisture_window_board;
        bit [smwa_pkg::DIVRES_W-1:0] div_res;
        bit [smwa_pkg::SLOPE_W-1:0]  slope;
        bit [smwa_pkg::SUM_W-1:0]    window_sum;
        bit [smwa_pkg::COUNT_W-1:0]  window_pairs;
        int                          pair_limit;
        int                          failures;
        t_window_result              finished_windows[$];

        function new(int limit);
            pair_limit   = limit;
            div_res      = 20'd10000;
            slope        = 32'd65536;
            window_sum   = '0;
            window_pairs = '0;
            failures     = 0;
        endfunction

        function void set_register(bit [smwa_pkg::CFG_IDX_W-1:0] idx,
                                   bit [smwa_pkg::CFG_DAT_W-1:0] data);
            if (idx == smwa_pkg::CFG_DIV_RES) begin
                div_res = data[smwa_pkg::DIVRES_W-1:0];
            end else if (idx == smwa_pkg::CFG_SLOPE) begin
                slope = data;
            end
        endfunction

        // Probe resistance times slope, truncated and capped at full moisture.
        function bit [smwa_pkg::MOIST_W-1:0] reading_percent(bit [smwa_pkg::SAMPLE_W-1:0] v);
            bit [63:0] num;
            bit [63:0] den;
            bit [63:0] q;
            if (v == smwa_pkg::FULL_SCALE) begin
                return smwa_pkg::MOISTURE_CAP;
            end
            num = 64'(slope) * 64'(v) * 64'(div_res);
            den = 64'(smwa_pkg::FULL_SCALE - v) << 16;
            q   = num / den;
            return (q > 64'(smwa_pkg::MOISTURE_CAP)) ? smwa_pkg::MOISTURE_CAP
                                                      : q[smwa_pkg::MOIST_W-1:0];
        endfunction

        function void note_input(smwa_pkg::t_op op, bit [smwa_pkg::SAMPLE_W-1:0] fwd,
                                 bit [smwa_pkg::SAMPLE_W-1:0] rev);
            bit [7:0]                 both;
            bit [smwa_pkg::SUM_W-1:0] quotient;
            t_window_result           res;
            if (op == smwa_pkg::OP_NONE) begin
                return;
            end
            if (op == smwa_pkg::OP_ADD || op == smwa_pkg::OP_ADD_FIN) begin
                if (int'(window_pairs) < pair_limit) begin
                    both = {1'b0, reading_percent(fwd)}
                         + {1'b0, reading_percent(smwa_pkg::FULL_SCALE - rev)};
                    window_sum   = window_sum + smwa_pkg::SUM_W'(both >> 1);
                    window_pairs = window_pairs + 1'b1;
                end
                if (op == smwa_pkg::OP_ADD) begin
                    return;
                end
            end
            quotient = (window_pairs == 0) ? '0
                     : window_sum / smwa_pkg::SUM_W'(window_pairs);
            res.average = quotient[smwa_pkg::MOIST_W-1:0];
            res.pairs   = window_pairs;
            finished_windows.push_back(res);
            window_sum   = '0;
            window_pairs = '0;
        endfunction

        function void check_result(bit [smwa_pkg::MOIST_W-1:0] average,
                                   bit [smwa_pkg::COUNT_W-1:0] pairs);
            t_window_result exp_res;
            if (finished_windows.size() == 0) begin
                $error("unexpected result: moisture_average %0d, pair_count %0d",
                       average, pairs);
                failures++;
                return;
            end
            exp_res = finished_windows.pop_front();
            if (average !== exp_res.average) begin
                $error("moisture_average mismatch: expected %0d, actual %0d",
                       exp_res.average, average);
                failures++;
            end
            if (pairs !== exp_res.pairs) begin
                $error("pair_count mismatch: expected %0d, actual %0d",
                       exp_res.pairs, pairs);
                failures++;
            end
        endfunction

        function int pending();
            return finished_windows.size();
        endfunction

        function void flag_leftovers();
            if (finished_windows.size() != 0) begin
                $error("%0d expected results never arrived", finished_windows.size());
                failures += finished_windows.size();
                finished_windows.delete();
            end
        endfunction
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           cfg_we;
    logic [smwa_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [smwa_pkg::CFG_DAT_W-1:0] cfg_data;

    smwa_in_if  in_if ();
    smwa_out_if out_if ();

    moisture_window_board board = new(TB_MAX_PAIRS);

    // Per-side idling: each stretch is either calm (no gaps) or has random gaps.
    int stretch_left [2];
    bit stretch_calm [2];

    soil_moisture_window_average #(
        .MAX_PAIRS (TB_MAX_PAIRS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Draw the wait before the next item on one side of the block.
    function int draw_gap(int side);
        if (stretch_left[side] <= 0) begin
            stretch_left[side] = $urandom_range(8, 40);
            stretch_calm[side] = ($urandom_range(0, 3) == 0);
        end
        stretch_left[side]--;
        return stretch_calm[side] ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // Favor the ends of the ADC range now and then, else a uniform reading.
    function bit [smwa_pkg::SAMPLE_W-1:0] draw_sample();
        case ($urandom_range(0, 7))
            0: begin
                return ($urandom_range(0, 1) == 0) ? 10'd0 : 10'd1;
            end
            1: begin
                return ($urandom_range(0, 1) == 0) ? smwa_pkg::FULL_SCALE
                                                    : smwa_pkg::FULL_SCALE - 10'd1;
            end
            default: begin
                return smwa_pkg::SAMPLE_W'($urandom_range(0, 1023));
            end
        endcase
    endfunction

    // Write one register; the update lands at the edge where the enable is seen high.
    task automatic write_register(logic [smwa_pkg::CFG_IDX_W-1:0] idx,
                                  logic [smwa_pkg::CFG_DAT_W-1:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        board.set_register(idx, data);
        cfg_we   <= 1'b0;
    endtask

    // Load both calibration registers; stuff junk into the unused upper bits
    // of the resistor word, which the block must drop.
    task automatic apply_calibration(bit [smwa_pkg::DIVRES_W-1:0] res_ohms,
                                     bit [smwa_pkg::SLOPE_W-1:0] slope_q);
        logic [smwa_pkg::CFG_DAT_W-1:0] junk;
        junk = $urandom();
        write_register(smwa_pkg::CFG_DIV_RES,
                       {junk[smwa_pkg::CFG_DAT_W-1:smwa_pkg::DIVRES_W], res_ohms});
        write_register(smwa_pkg::CFG_SLOPE, slope_q);
    endtask

    // Offer one item and hold it until the block takes it. Keep valid high
    // across back-to-back items so it is never dropped and raised in one step.
    task automatic send_item(smwa_pkg::t_op op, bit [smwa_pkg::SAMPLE_W-1:0] fwd,
                             bit [smwa_pkg::SAMPLE_W-1:0] rev);
        int gap;
        gap = draw_gap(SIDE_IN);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid          <= 1'b1;
        in_if.operation      <= op;
        in_if.forward_sample <= fwd;
        in_if.reverse_sample <= rev;
        do @(posedge i_clk); while (!(in_if.valid && in_if.ready));
        board.note_input(smwa_pkg::t_op'(in_if.operation), in_if.forward_sample,
                         in_if.reverse_sample);
    endtask

    // Wait for every expected result, then let any trailing pair item finish.
    task automatic drain_block();
        int waited;
        waited = 0;
        // Drop valid at the accepting edge so the last item is not taken twice.
        if (in_if.valid) begin
            in_if.valid <= 1'b0;
        end
        while (board.pending() > 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        board.flag_leftovers();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Corner cases under reset calibration (R = 10000, slope = 1.0).
    task automatic run_directed();
        // Empty window: finish with nothing collected.
        send_item(smwa_pkg::OP_FIN, 10'd0, 10'd0);
        // Zero readings on both polarities, then full scale on both.
        send_item(smwa_pkg::OP_ADD, 10'd0, smwa_pkg::FULL_SCALE);
        send_item(smwa_pkg::OP_ADD_FIN, smwa_pkg::FULL_SCALE, 10'd0);
        // Small readings that stay below the cap; odd pair sum truncates.
        send_item(smwa_pkg::OP_ADD, 10'd3, 10'd1014);
        send_item(smwa_pkg::OP_ADD_FIN, 10'd9, 10'd1020);
        // Mid-scale product far above the cap; unused op code in the middle.
        send_item(smwa_pkg::OP_ADD, 10'd512, 10'd511);
        send_item(smwa_pkg::OP_NONE, smwa_pkg::FULL_SCALE, smwa_pkg::FULL_SCALE);
        send_item(smwa_pkg::OP_FIN, 10'd0, 10'd0);
        // Short window of readings near zero, closed by a pair with finish.
        send_item(smwa_pkg::OP_ADD, 10'd7, 10'd1000);
        send_item(smwa_pkg::OP_ADD_FIN, 10'd8, 10'd1001);
    endtask

    // Mostly well-formed windows of random length, sprinkled with unused op
    // codes; some windows stay open across several runs of items.
    task automatic run_random(int target);
        int sent;
        int len;
        sent = 0;
        while (sent < target) begin
            len = $urandom_range(0, MAX_WINDOW);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_item(smwa_pkg::OP_NONE, draw_sample(), draw_sample());
                end
                send_item(smwa_pkg::OP_ADD, draw_sample(), draw_sample());
                sent++;
            end
            // Close the window; leave it open now and then so it spans items.
            case ($urandom_range(0, 5))
                0, 1, 2: begin
                    send_item(smwa_pkg::OP_ADD_FIN, draw_sample(), draw_sample());
                    sent++;
                end
                3, 4: begin
                    send_item(smwa_pkg::OP_FIN, draw_sample(), draw_sample());
                    sent++;
                end
                default: begin
                end
            endcase
        end
    endtask

    // Choose the calibration of each phase: reset values, a small slope,
    // both ends of each register, writes to unused indexes, then random ones.
    task automatic set_phase_calibration(int phase);
        case (phase)
            0: apply_calibration(20'd10000, 32'd65536);
            1: apply_calibration(20'd10000, 32'd66);
            2: apply_calibration(20'd0, $urandom());
            3: begin
                apply_calibration(20'd1000000, 32'hFFFF_FFFF);
                write_register(CFG_UNUSED_A, $urandom());
                write_register(CFG_UNUSED_B, $urandom());
            end
            4: apply_calibration(20'hF_FFFF, 32'($urandom_range(1, 300)));
            5: apply_calibration(smwa_pkg::DIVRES_W'($urandom_range(0, 20'hF_FFFF)), 32'd0);
            default: begin
                apply_calibration(smwa_pkg::DIVRES_W'($urandom_range(0, 20'hF_FFFF)
                                                      >> $urandom_range(0, 19)),
                                  $urandom() >> $urandom_range(0, 31));
            end
        endcase
    endtask

    // Result side: accept finished windows with random back-pressure.
    initial begin
        int gap;
        out_if.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            gap = draw_gap(SIDE_OUT);
            if (gap > 0) begin
                out_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_if.valid && out_if.ready));
            board.check_result(out_if.moisture_average, out_if.pair_count);
        end
    end

    // Main sequence: reset once, then one phase per calibration setting.
    initial begin
        i_rst_n              <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_idx              <= smwa_pkg::CFG_DIV_RES;
        cfg_data             <= '0;
        in_if.valid          <= 1'b0;
        in_if.operation      <= smwa_pkg::OP_NONE;
        in_if.forward_sample <= '0;
        in_if.reverse_sample <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int phase = 0; phase < PHASES; phase++) begin
            set_phase_calibration(phase);
            if (phase == 0) begin
                run_directed();
            end
            run_random(ITEMS_PER_PHASE);
            drain_block();
        end

        if (board.failures == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(TIMEOUT_UNITS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/smwa_pkg.sv
hdl/smwa_ifs.sv
hdl/smwa_ctrl.sv
hdl/smwa_dp.sv
hdl/soil_moisture_window_average.sv
hdl/smwa_chk.sv
tb/soil_moisture_window_average_tb.sv
